// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/pps_pkg.sv
// types and constants of the preemptive priority scheduler
package pps_pkg;

   localparam int NPROC_DEFAULT = 16;

   localparam int CFG_ADDR_W = 3;
   localparam logic [CFG_ADDR_W-1:0] ADDR_TASK_COUNT = 3'd0;
   localparam logic [4:0] TASK_COUNT_RESET = 5'd1;

   localparam logic [23:0] CLOCK_MAX = 24'hFFFFFF;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_TICK = 1'b1
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [3:0]  slot;
      logic [7:0]  task_id;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  prio;
   } req_type;

   typedef struct packed {
      logic [7:0]  running_id;
      logic        idle;
      logic        switched;
      logic        finished;
      logic [23:0] finish_time;
      logic [23:0] turnaround;
      logic [23:0] waiting;
      logic        all_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  prio;
      logic [15:0] remaining;
   } task_rec_type;

endpackage

// File: rtl/preemptive_priority_scheduler_unit.sv
// preemptive priority scheduler: task table, selection scan and time accounting
// tick: SCAN reads the n = min(task_count, NPROC) slots in use, then LAST, STEP and REPORT;
//   n = 0 goes straight to STEP; load: straight to REPORT; a new transfer is taken only in
//   IDLE; the scan reads one table entry per cycle through the single table read port; the
//   next transfer is taken while an earlier result still waits on the result side
// reset (synchronous): clock, finished flags, last served, control cleared, task_count 1
`include "assert_macros.svh"

module preemptive_priority_scheduler_unit
   import pps_pkg::*;
#(
   parameter int NPROC = NPROC_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CFG_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int IDX_W  = (NPROC > 1) ? $clog2(NPROC) : 1;
   localparam int CNT_W  = $clog2(NPROC + 1);
   localparam int WIDE_W = CNT_W + 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_STEP,
      ST_REPORT
   } state_type;

   // sequencer and scheduler state
   state_type          state_ff;
   logic [4:0]         task_count_ff;
   logic [23:0]        clock_ff;
   logic [NPROC-1:0]   done_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               last_vld_ff;
   logic [IDX_W-1:0]   last_slot_ff;

   // scan pipeline: read stage and best-so-far
   logic               rd_pend_ff;
   logic [IDX_W-1:0]   rd_slot_ff;
   task_rec_type       rd_rec_ff;
   logic               best_vld_ff;
   logic [IDX_W-1:0]   best_slot_ff;
   task_rec_type       best_rec_ff;

   // step results waiting for the report cycle
   logic [23:0]        tat_ff;
   logic               fin_ff;
   logic               sw_ff;
   logic               is_load_ff;

   // result register
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   // task table, one write port and one registered read port
   task_rec_type       mem [NPROC];
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   task_rec_type       mem_wdata;

   logic [WIDE_W-1:0]  n_wide;
   logic [CNT_W-1:0]   n_cnt;
   logic [NPROC-1:0]   use_mask;
   logic               all_done;
   logic               accept;
   logic               load_ok;
   logic               last_issue;
   logic               eligible;
   logic               better;
   logic               take;
   logic [23:0]        clock_inc;
   logic [15:0]        rem_dec;
   logic [23:0]        burst_ext;
   logic [23:0]        wait_val;
   logic               out_free;
   logic               cfg_write;

   // register port, no wait states
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata    = (paddr == ADDR_TASK_COUNT) ? 32'(task_count_ff) : '0;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // slots in use, count saturates at the table depth
   assign n_wide = (WIDE_W'(task_count_ff) > WIDE_W'(NPROC)) ? WIDE_W'(NPROC)
                                                             : WIDE_W'(task_count_ff);
   assign n_cnt  = CNT_W'(n_wide);

   always_comb begin
      for (int i = 0; i < NPROC; i++) begin
         use_mask[i] = (CNT_W'(i) < n_cnt);
      end
   end

   // every slot in use has no service left
   assign all_done = &(done_ff | ~use_mask);

   // loads beyond the table are dropped
   assign load_ok = (int'(req_data.slot) < NPROC);

   assign last_issue = (CNT_W'(idx_ff) == (n_cnt - CNT_W'(1)));

   // compare stage: eligible entry beats current best on prio, then arrival;
   // lower slot wins a full tie since slots come in ascending order
   assign eligible = rd_pend_ff && !done_ff[rd_slot_ff]
                  && (24'(rd_rec_ff.arrival) <= clock_ff);
   assign better   = !best_vld_ff
                  || (rd_rec_ff.prio < best_rec_ff.prio)
                  || ((rd_rec_ff.prio == best_rec_ff.prio)
                      && (rd_rec_ff.arrival < best_rec_ff.arrival));
   assign take     = eligible && better;

   // saturating tick clock
   assign clock_inc = (clock_ff == CLOCK_MAX) ? clock_ff : clock_ff + 24'd1;
   assign rem_dec   = best_rec_ff.remaining - 16'd1;

   // waiting time floors at zero once the clock has saturated
   assign burst_ext = 24'(best_rec_ff.burst);
   assign wait_val  = (tat_ff >= burst_ext) ? (tat_ff - burst_ext) : '0;

   // table write: a load transfer or the decrement of the served task
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = IDX_W'(req_data.slot);
      mem_wdata = '{task_id:   req_data.task_id,
                    arrival:   req_data.arrival,
                    burst:     req_data.burst,
                    prio:      req_data.prio,
                    remaining: req_data.burst};
      if (state_ff == ST_STEP) begin
         mem_we              = best_vld_ff;
         mem_waddr           = best_slot_ff;
         mem_wdata           = best_rec_ff;
         mem_wdata.remaining = rem_dec;
      end else if (accept && (req_data.action == ACT_LOAD) && load_ok) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_rec_ff <= mem[idx_ff];
   end

   // result fields: loads report only all_done, idle ticks the idle flag
   always_comb begin
      rsp_in          = '0;
      rsp_in.all_done = all_done;
      if (!is_load_ff) begin
         if (!best_vld_ff) begin
            rsp_in.idle = 1'b1;
         end else begin
            rsp_in.running_id = best_rec_ff.task_id;
            rsp_in.switched   = sw_ff;
            rsp_in.finished   = fin_ff;
            if (fin_ff) begin
               rsp_in.finish_time = clock_ff;
               rsp_in.turnaround  = tat_ff;
               rsp_in.waiting     = wait_val;
            end
         end
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         task_count_ff <= TASK_COUNT_RESET;
         clock_ff      <= '0;
         done_ff       <= '0;
         idx_ff        <= '0;
         last_vld_ff   <= 1'b0;
         rd_pend_ff    <= 1'b0;
         best_vld_ff   <= 1'b0;
         is_load_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cfg_write && pready && (paddr == ADDR_TASK_COUNT)) begin
            task_count_ff <= pwdata[4:0];
         end
         // the report cycle sets the result register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_REPORT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_data.action == ACT_LOAD) begin
                     // a reload clears the finished flag, a zero burst is done at once
                     if (load_ok) begin
                        done_ff[IDX_W'(req_data.slot)] <= (req_data.burst == 16'd0);
                     end
                     is_load_ff <= 1'b1;
                     state_ff   <= ST_REPORT;
                  end else begin
                     is_load_ff  <= 1'b0;
                     idx_ff      <= '0;
                     best_vld_ff <= 1'b0;
                     rd_pend_ff  <= 1'b0;
                     state_ff    <= (n_cnt == '0) ? ST_STEP : ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               // issue read of idx, compare the entry read last cycle
               rd_pend_ff <= 1'b1;
               rd_slot_ff <= idx_ff;
               idx_ff     <= idx_ff + IDX_W'(1);
               if (take) begin
                  best_vld_ff  <= 1'b1;
                  best_slot_ff <= rd_slot_ff;
                  best_rec_ff  <= rd_rec_ff;
               end
               if (last_issue) begin
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               rd_pend_ff <= 1'b0;
               if (take) begin
                  best_vld_ff  <= 1'b1;
                  best_slot_ff <= rd_slot_ff;
                  best_rec_ff  <= rd_rec_ff;
               end
               state_ff <= ST_STEP;
            end
            ST_STEP: begin
               clock_ff <= clock_inc;
               tat_ff   <= clock_inc - 24'(best_rec_ff.arrival);
               fin_ff   <= best_vld_ff && (rem_dec == 16'd0);
               sw_ff    <= best_vld_ff && (!last_vld_ff || (last_slot_ff != best_slot_ff));
               if (best_vld_ff) begin
                  last_vld_ff  <= 1'b1;
                  last_slot_ff <= best_slot_ff;
                  if (rem_dec == 16'd0) begin
                     done_ff[best_slot_ff] <= 1'b1;
                  end
               end
               state_ff <= ST_REPORT;
            end
            ST_REPORT: begin
               // hold until the result register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= rsp_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // scan index never runs past the slots in use
   `ASSERT_IMPLY(a_scan_idx, clock, reset, state_ff == ST_SCAN, CNT_W'(idx_ff) < n_cnt)
   // the served task was not finished before this tick
   `ASSERT_IMPLY(a_best_live, clock, reset, (state_ff == ST_STEP) && best_vld_ff, !done_ff[best_slot_ff])
   // a completion is never reported on an idle tick
   `ASSERT_IMPLY(a_fin_busy, clock, reset, rsp_valid_ff && rsp_ff.finished, !rsp_ff.idle)
   // after a transfer the block is busy
   `ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)

endmodule
